// ===== rtl/lprt_pkg.sv =====
`timescale 1ns / 1ps

package lprt_pkg;

  // table geometry
  localparam int unsigned LPRT_ENTRIES = 16;
  localparam int unsigned ADDR_W       = 32;
  localparam int unsigned LEN_W        = 6;
  localparam int unsigned PORT_W       = 8;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);
  localparam logic [ADDR_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

  // item opcodes
  typedef enum logic [0:0] {
    OP_ADD    = 1'b0,
    OP_LOOKUP = 1'b1
  } lprt_op_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_ADDED = 2'd0,
    ST_FULL  = 2'd1,
    ST_HIT   = 2'd2,
    ST_MISS  = 2'd3
  } lprt_status_e;

  // entry write bundle
  typedef struct packed {
    logic [ADDR_W-1:0] net;
    logic [LEN_W-1:0]  len;
    logic [PORT_W-1:0] port;
  } lprt_wr_t;

  // search beat travelling down the cell row
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic [LEN_W-1:0]  best_len;
    logic [PORT_W-1:0] best_port;
  } lprt_beat_t;

  // clamp prefix length to 32
  function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
    sat_len = (len > MAX_LEN) ? MAX_LEN : len;
  endfunction

  // leading-ones mask for a clamped prefix length
  function automatic logic [ADDR_W-1:0] prefix_mask(input logic [LEN_W-1:0] len);
    prefix_mask = ~(ALL_ONES >> sat_len(len));
  endfunction

endpackage

// ===== rtl/lprt_cell.sv =====
`timescale 1ns / 1ps

module lprt_cell
  import lprt_pkg::*;
#(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 5
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CNT_W-1:0] count_i,
  input  logic             wr_en_i,
  input  lprt_wr_t         wr_i,
  input  lprt_beat_t       beat_i,
  output lprt_beat_t       beat_o
);

  lprt_wr_t   entry_q;
  logic       used;
  logic       match;
  logic       take;
  logic       valid_q;
  lprt_beat_t beat_d;
  lprt_beat_t beat_q;

  // entry storage, written once by its add
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      entry_q <= wr_i;
    end
  end

  // entry is live once the fill count has passed this cell
  assign used  = count_i > CNT_W'(INDEX);
  assign match = used && ((beat_i.addr & prefix_mask(entry_q.len)) == entry_q.net);
  // strictly longer wins so earlier entries keep ties
  assign take  = match && (!beat_i.found || (entry_q.len > beat_i.best_len));

  // update the running best
  always_comb begin
    beat_d = beat_i;
    if (take) begin
      beat_d.found     = 1'b1;
      beat_d.best_len  = entry_q.len;
      beat_d.best_port = entry_q.port;
    end
  end

  // beat valid to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  // beat payload to the next cell
  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  always_comb begin
    beat_o       = beat_q;
    beat_o.valid = valid_q;
  end

endmodule

// ===== rtl/longest_prefix_route_table.sv =====
`timescale 1ns / 1ps
// IPv4 route table with longest prefix match, ENTRIES routes deep.
// Input channel: in_valid_i / in_stall_o carry one beat per item: opcode_i
// (add or lookup), address_i, prefix_length_i and egress_port_i.
// Output channel: out_valid_o / out_stall_i carry one result beat per item:
// status_o (added, full, hit, miss) and port_out_o.
// An add masks the address, stores the route in the next free cell and
// answers in the cycle after it is taken; a full table drops it.
// A lookup is walked through a row of ENTRIES cells, one cell per cycle,
// each comparing its own route and keeping the longest match; the result
// is registered when the lookup beat leaves the last cell.
// One item is in the block at a time: an add sustains one item per cycle
// while out_stall_i is low; a lookup holds the next item off until it ends.
// The output register holds a result while out_stall_i is high; a new item
// is only taken when that register is empty or being emptied.
// Reset empties the table (fill count to zero) and clears both channels.
module longest_prefix_route_table
  import lprt_pkg::*;
#(
  parameter int unsigned ENTRIES = LPRT_ENTRIES
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic [LEN_W-1:0]  prefix_length_i,
  input  logic [PORT_W-1:0] egress_port_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        status_o,
  output logic [PORT_W-1:0] port_out_o
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [0:0] {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e            state_q;
  logic [CNT_W-1:0]  count_q;
  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [PORT_W-1:0] port_q;

  logic              in_fire;
  logic              is_add;
  logic              full;
  logic              res_load;
  lprt_wr_t          wr;
  lprt_beat_t        chain [ENTRIES+1];

  assign in_stall_o = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign is_add     = (opcode_i == OP_ADD);
  assign full       = (count_q == CNT_W'(ENTRIES));

  // a result beat is loaded by an add or by the end of a search
  assign res_load = ((state_q == S_IDLE) && in_fire && is_add) ||
                    ((state_q == S_SEARCH) && chain[ENTRIES].valid);

  // masked route for the next free cell
  assign wr.net  = address_i & prefix_mask(prefix_length_i);
  assign wr.len  = sat_len(prefix_length_i);
  assign wr.port = egress_port_i;

  // lookup beat into the head of the row
  always_comb begin
    chain[0].valid     = in_fire && (opcode_i == OP_LOOKUP);
    chain[0].addr      = address_i;
    chain[0].found     = 1'b0;
    chain[0].best_len  = '0;
    chain[0].best_port = '0;
  end

  // row of route cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    lprt_cell #(
      .INDEX (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .count_i (count_q),
      .wr_en_i (in_fire && is_add && (count_q == CNT_W'(g))),
      .wr_i    (wr),
      .beat_i  (chain[g]),
      .beat_o  (chain[g+1])
    );
  end

  // sequencer, fill count and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      status_q    <= ST_ADDED;
      port_q      <= '0;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            if (is_add) begin
              port_q <= '0;
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                status_q <= ST_ADDED;
                count_q  <= count_q + CNT_W'(1);
              end
            end else begin
              state_q <= S_SEARCH;
            end
          end
        end
        S_SEARCH: begin
          if (chain[ENTRIES].valid) begin
            state_q <= S_IDLE;
            if (chain[ENTRIES].found) begin
              status_q <= ST_HIT;
              port_q   <= chain[ENTRIES].best_port;
            end else begin
              status_q <= ST_MISS;
              port_q   <= '0;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign port_out_o  = port_q;

endmodule

// ===== rtl/lprt_checker.sv =====
`timescale 1ns / 1ps

module lprt_checker
  import lprt_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              opcode_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input logic [1:0]        status_o,
  input logic [PORT_W-1:0] port_out_o
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(port_out_o))
    else $error("stalled result beat changed");

  // an add answers on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == OP_ADD)
      |=> out_valid_o && (status_o == ST_ADDED || status_o == ST_FULL))
    else $error("add result missing");

  // a lookup holds off the next item while it searches
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (opcode_i == OP_LOOKUP) |=> in_stall_o && !out_valid_o)
    else $error("item taken during lookup");

  // only a hit carries a port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ADDED || status_o == ST_FULL || status_o == ST_MISS)
      |-> port_out_o == '0)
    else $error("non-zero port on a result without a hit");

endmodule

bind longest_prefix_route_table lprt_checker u_lprt_checker (.*);
